// ===== rtl/mcst_pkg.sv =====
// ----------------------------------------------------------------------------
// mcst_pkg
// shared codes and types of the contact slot tracker
// ----------------------------------------------------------------------------
package mcst_pkg;

    localparam logic [2:0] CMD_TIP   = 3'd0;
    localparam logic [2:0] CMD_IDENT = 3'd1;
    localparam logic [2:0] CMD_PRESS = 3'd2;
    localparam logic [2:0] CMD_X     = 3'd3;
    localparam logic [2:0] CMD_Y     = 3'd4;
    localparam logic [2:0] CMD_COUNT = 3'd5;

    localparam logic [1:0] CLASS_IDENT      = 2'd0;
    localparam logic [1:0] CLASS_NUMBER     = 2'd1;
    localparam logic [1:0] CLASS_IDENT_DROP = 2'd2;
    localparam logic [1:0] CLASS_IDENT_M1   = 2'd3;

    localparam logic [1:0] KIND_RELEASE = 2'd0;
    localparam logic [1:0] KIND_ACTIVE  = 2'd1;
    localparam logic [1:0] KIND_FRAME   = 2'd2;

    localparam logic [1:0] REG_DEVICE_CLASS     = 2'd0;
    localparam logic [1:0] REG_MAX_CONTACTS     = 2'd1;
    localparam logic [1:0] REG_PRESSURE_ENABLED = 2'd2;

    localparam int SLOT_W = 4;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       x;
        logic [15:0]       y;
        logic [15:0]       pressure;
    } slot_wr_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot_index;
        logic [15:0]       tracking_id;
        logic [15:0]       pos_x;
        logic [15:0]       pos_y;
        logic [15:0]       pressure;
        logic              pressure_present;
        logic              touching;
        logic              last;
    } result_t;

endpackage

// ===== rtl/mcst_ram.sv =====
// ----------------------------------------------------------------------------
// mcst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mcst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mcst_contact.sv =====
// ----------------------------------------------------------------------------
// mcst_contact
// collects report fields into the current contact, picks its slot and
// detects the end of a frame
// ----------------------------------------------------------------------------
module mcst_contact import mcst_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [2:0]  command,
    input  logic [15:0] value,
    input  logic [1:0]  device_class,
    input  logic [4:0]  slots_used,
    output slot_wr_t    slot_wr,
    output logic        frame_go
);

    logic        valid_reg, valid_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] press_reg, press_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  final_reg, final_next;

    logic [15:0] cand;
    logic        drop;
    logic        in_range;

    always_comb
    begin
        cand = ident_reg;
        drop = 1'b0;
        case (device_class)
            CLASS_IDENT:
            begin
                cand = ident_reg;
            end
            CLASS_NUMBER:
            begin
                cand = 16'(index_reg);
            end
            CLASS_IDENT_DROP:
            begin
                cand = ident_reg;
                drop = (ident_reg == 16'd0) && (index_reg != 8'd0);
            end
            CLASS_IDENT_M1:
            begin
                cand = ident_reg - 16'd1;
                drop = (ident_reg == 16'd0);
            end
            default:
            begin
                cand = ident_reg;
            end
        endcase
        in_range = !drop && (cand < 16'(slots_used));
    end

    always_comb
    begin
        valid_next = valid_reg;
        ident_next = ident_reg;
        x_next     = x_reg;
        press_next = press_reg;
        index_next = index_reg;
        final_next = final_reg;
        frame_go   = 1'b0;
        slot_wr    = '0;
        slot_wr.slot     = cand[SLOT_W-1:0];
        slot_wr.x        = x_reg;
        slot_wr.y        = value;
        slot_wr.pressure = press_reg;
        if (accept)
        begin
            case (command)
                CMD_TIP:   valid_next = (value != 16'd0);
                CMD_IDENT: ident_next = value;
                CMD_PRESS: press_next = value;
                CMD_X:     x_next = value;
                CMD_Y:
                begin
                    slot_wr.en = valid_reg && in_range;
                    index_next = index_reg + 8'd1;
                end
                CMD_COUNT:
                begin
                    if (value != 16'd0)
                    begin
                        final_next = 8'(value - 16'd1);
                    end
                    if (index_reg > final_next)
                    begin
                        frame_go   = 1'b1;
                        index_next = 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ident_reg <= 16'd0;
            x_reg     <= 16'd0;
            press_reg <= 16'd0;
            index_reg <= 8'd0;
            final_reg <= 8'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            ident_reg <= ident_next;
            x_reg     <= x_next;
            press_reg <= press_next;
            index_reg <= index_next;
            final_reg <= final_next;
        end
    end

endmodule

// ===== rtl/mcst_walker.sv =====
// ----------------------------------------------------------------------------
// mcst_walker
// slot memories and the frame-end walk that reports releases, active
// contacts and the emulation beat of the oldest contact
// ----------------------------------------------------------------------------
module mcst_walker import mcst_pkg::*; #(
    parameter int NSLOT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  slot_wr_t   slot_wr,
    input  logic       frame_go,
    input  logic [4:0] slots_used,
    input  logic       pressure_enabled,
    output logic       busy,
    output logic       strobe,
    output result_t    result
);

    localparam int AW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int IW = $clog2(NSLOT + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;

    logic [1:0]       state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pidx_reg, pidx_next;
    logic [NSLOT-1:0] fresh_reg, fresh_next;
    logic [NSLOT-1:0] was_reg, was_next;
    logic [15:0]      nid_reg, nid_next;
    logic             found_reg, found_next;
    logic [AW-1:0]    old_slot_reg, old_slot_next;
    logic [15:0]      old_tid_reg, old_tid_next;
    logic [15:0]      old_x_reg, old_x_next;
    logic [15:0]      old_y_reg, old_y_next;
    logic             strobe_reg, strobe_next;
    result_t          res_reg, res_next;

    logic [47:0] data_rd;
    logic [15:0] tid_rd;
    logic        tid_we;
    logic        cur_fresh, cur_was;
    logic [15:0] cur_tid, cur_x, cur_y, cur_p;
    logic [15:0] age_diff;

    mcst_ram #(.WIDTH(48), .DEPTH(NSLOT)) u_data_ram (
        .clk   (clk),
        .we    (slot_wr.en),
        .waddr (slot_wr.slot[AW-1:0]),
        .wdata ({slot_wr.x, slot_wr.y, slot_wr.pressure}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (data_rd)
    );

    mcst_ram #(.WIDTH(16), .DEPTH(NSLOT)) u_tid_ram (
        .clk   (clk),
        .we    (tid_we),
        .waddr (pidx_reg),
        .wdata (nid_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (tid_rd)
    );

    assign cur_fresh = fresh_reg[pidx_reg];
    assign cur_was   = was_reg[pidx_reg];
    assign cur_tid   = cur_was ? tid_rd : nid_reg;
    assign cur_x     = data_rd[47:32];
    assign cur_y     = data_rd[31:16];
    assign cur_p     = data_rd[15:0];
    assign age_diff  = cur_tid - old_tid_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        fresh_next    = fresh_reg;
        was_next      = was_reg;
        nid_next      = nid_reg;
        found_next    = found_reg;
        old_slot_next = old_slot_reg;
        old_tid_next  = old_tid_reg;
        old_x_next    = old_x_reg;
        old_y_next    = old_y_reg;
        strobe_next   = 1'b0;
        res_next      = '0;
        tid_we        = 1'b0;
        if (slot_wr.en)
        begin
            fresh_next[slot_wr.slot[AW-1:0]] = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_go)
                begin
                    state_next = ST_WALK;
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_WALK:
            begin
                if (pend_reg)
                begin
                    if (!cur_fresh && cur_was)
                    begin
                        strobe_next          = 1'b1;
                        res_next.kind        = KIND_RELEASE;
                        res_next.slot_index  = SLOT_W'(pidx_reg);
                        was_next[pidx_reg]   = 1'b0;
                    end
                    else if (cur_fresh)
                    begin
                        if (!cur_was)
                        begin
                            tid_we   = 1'b1;
                            nid_next = nid_reg + 16'd1;
                        end
                        strobe_next               = 1'b1;
                        res_next.kind             = KIND_ACTIVE;
                        res_next.slot_index       = SLOT_W'(pidx_reg);
                        res_next.tracking_id      = cur_tid;
                        res_next.pos_x            = cur_x;
                        res_next.pos_y            = cur_y;
                        res_next.pressure         = pressure_enabled ? cur_p : 16'd0;
                        res_next.pressure_present = pressure_enabled;
                        was_next[pidx_reg]        = 1'b1;
                        fresh_next[pidx_reg]      = 1'b0;
                        if (!found_reg || age_diff[15])
                        begin
                            found_next    = 1'b1;
                            old_slot_next = pidx_reg;
                            old_tid_next  = cur_tid;
                            old_x_next    = cur_x;
                            old_y_next    = cur_y;
                        end
                    end
                end
                if (5'(idx_reg) < slots_used)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + IW'(1);
                end
                else if (!pend_reg)
                begin
                    strobe_next      = 1'b1;
                    res_next.kind    = KIND_FRAME;
                    res_next.last    = 1'b1;
                    res_next.touching = found_reg;
                    if (found_reg)
                    begin
                        res_next.slot_index  = SLOT_W'(old_slot_reg);
                        res_next.tracking_id = old_tid_reg;
                        res_next.pos_x       = old_x_reg;
                        res_next.pos_y       = old_y_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            pidx_reg   <= '0;
            fresh_reg  <= '0;
            was_reg    <= '0;
            nid_reg    <= 16'd0;
            found_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            pidx_reg   <= pidx_next;
            fresh_reg  <= fresh_next;
            was_reg    <= was_next;
            nid_reg    <= nid_next;
            found_reg  <= found_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_slot_reg <= old_slot_next;
        old_tid_reg  <= old_tid_next;
        old_x_reg    <= old_x_next;
        old_y_reg    <= old_y_next;
        res_reg      <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && res_reg.last |-> state_reg == ST_IDLE)
        else $error("frame end beat shown while walk still running");

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame_go |-> state_reg == ST_IDLE)
        else $error("frame start while walk running");

    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ST_WALK && idx_reg != '0)
        else $error("slot read pending outside walk");

    a_id_walk: assert property (@(posedge clk) disable iff (!rst_n)
        nid_reg != $past(nid_reg) |-> state_reg == ST_WALK)
        else $error("tracking id advanced outside walk");

    a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
        slot_wr.en |-> state_reg == ST_IDLE)
        else $error("slot write during walk");

endmodule

// ===== rtl/multitouch_contact_slot_tracker.sv =====
// ----------------------------------------------------------------------------
// multitouch_contact_slot_tracker
// collects touch report fields into slots and reports them at frame end
// ----------------------------------------------------------------------------
// usage:
//   command/value carry one report field per beat; a beat is taken at a
//   clock edge with start high and busy low. tip, id, pressure and x
//   fields are stored in the current contact; a y field closes the
//   contact and, if it is down and in range, writes its slot in the
//   same cycle. a contact count field that completes the frame raises
//   busy and walks the slots, one slot read per cycle from the slot
//   rams, before busy falls again.
//   each release or active report comes out as one beat with strobe high
//   for one cycle; the frame closes with a beat with last high that holds
//   the oldest contact, if any. results cannot be held off by the receiver.
//   wr_en/wr_index/wr_data write device_class, max_contacts and
//   pressure_enabled; write only while busy is low.
//   reset clears the contact state, slot flags and id counter; the slot
//   rams need no clearing since entries are used only after being written.
// ----------------------------------------------------------------------------
module multitouch_contact_slot_tracker import mcst_pkg::*; #(
    parameter int MAX_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] value,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [4:0]  wr_data,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic [3:0]  slot_index,
    output logic [15:0] tracking_id,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [15:0] pressure,
    output logic        pressure_present,
    output logic        touching,
    output logic        last
);

    localparam int NSLOT = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;

    logic [1:0] device_class_reg;
    logic [4:0] max_contacts_reg;
    logic       pressure_enabled_reg;
    logic [4:0] slots_used;
    logic       accept;
    logic       frame_go;
    slot_wr_t   slot_wr;
    result_t    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_class_reg     <= 2'd0;
            max_contacts_reg     <= 5'd2;
            pressure_enabled_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DEVICE_CLASS:     device_class_reg     <= wr_data[1:0];
                REG_MAX_CONTACTS:     max_contacts_reg     <= wr_data;
                REG_PRESSURE_ENABLED: pressure_enabled_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign slots_used = (max_contacts_reg > 5'(NSLOT)) ? 5'(NSLOT) : max_contacts_reg;
    assign accept     = start && !busy;

    mcst_contact u_contact (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .value        (value),
        .device_class (device_class_reg),
        .slots_used   (slots_used),
        .slot_wr      (slot_wr),
        .frame_go     (frame_go)
    );

    mcst_walker #(.NSLOT(NSLOT)) u_walker (
        .clk              (clk),
        .rst_n            (rst_n),
        .slot_wr          (slot_wr),
        .frame_go         (frame_go),
        .slots_used       (slots_used),
        .pressure_enabled (pressure_enabled_reg),
        .busy             (busy),
        .strobe           (strobe),
        .result           (result)
    );

    assign kind             = result.kind;
    assign slot_index       = result.slot_index;
    assign tracking_id      = result.tracking_id;
    assign pos_x            = result.pos_x;
    assign pos_y            = result.pos_y;
    assign pressure         = result.pressure;
    assign pressure_present = result.pressure_present;
    assign touching         = result.touching;
    assign last             = result.last;

endmodule
